FILE: sv/label_propagation_components_macros.svh
// Assertion macros for the label propagation block
`ifndef LABEL_PROPAGATION_COMPONENTS_MACROS_SVH
`define LABEL_PROPAGATION_COMPONENTS_MACROS_SVH
`define LPC_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define LPC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

FILE: sv/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Types and codes shared by the label propagation block.
// ----------------------------------------------------------------------------
package lpc_pkg;
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_RUN  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_NOP  = 2'd3;

    localparam int VCNT_W = 11;
    localparam int PLIM_W = 12;
    localparam logic [VCNT_W-1:0] VCNT_RESET = 11'd1024;
    localparam logic [PLIM_W-1:0] PLIM_RESET = 12'd1000;

    localparam logic [0:0] ADDR_VCNT = 1'b0;
    localparam logic [0:0] ADDR_PLIM = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [9:0] vertex;
        logic [9:0] neighbor;
    } req_t;

    typedef struct packed {
        logic [9:0]  label;
        logic [10:0] component_count;
        logic [11:0] pass_count;
        logic        converged;
        logic        error;
    } rsp_t;
endpackage

FILE: sv/lpc_if.sv
// ----------------------------------------------------------------------------
// lpc_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface lpc_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/label_propagation_components.sv
// ----------------------------------------------------------------------------
// label_propagation_components
// Label propagation connected components over a loaded adjacency list.
// ----------------------------------------------------------------------------
// Usage: req channel (sink) takes words {req_type, vertex, neighbor}; rsp
// channel (source) returns one word per load, run or read; type 3 is dropped.
// Registers over APB: 0x0 vertex_count, 0x4 pass_limit.
// Steps: a load fills in the list end of each source vertex that it skips
// before it answers; a read after a run reads the label memory. A run
// initialises every label, makes passes over the vertices and their lists
// up to pass_limit, clears the seen marks and counts the components, paced
// by the single label memory port and the one shared min compare unit.
// One word at a time: the request side is not ready while a word is in work
// or while a finished result waits; a stalled receiver holds the result.
// Reset: asynchronous, clears the entry count, error flag and run flag;
// the memories hold no reset value.
// ----------------------------------------------------------------------------
module label_propagation_components #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_ENTRIES  = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    lpc_if.sink         req,
    lpc_if.source       rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpc_pkg::*;
    logic [VCNT_W-1:0] vcnt;
    logic [PLIM_W-1:0] plim;

    lpc_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .vcnt, .plim
    );

    lpc_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_ENTRIES(MAX_ENTRIES)) u_engine (
        .clk, .rst_n, .vcnt, .plim,
        .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
        .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
    );
endmodule

FILE: sv/lpc_regs.sv
// ----------------------------------------------------------------------------
// lpc_regs
// APB register file: vertex_count and pass_limit.
// ----------------------------------------------------------------------------
module lpc_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [lpc_pkg::VCNT_W-1:0] vcnt,
    output logic [lpc_pkg::PLIM_W-1:0] plim
);
    import lpc_pkg::*;
    logic [VCNT_W-1:0] vcnt_reg;
    logic [PLIM_W-1:0] plim_reg;
    logic              wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg <= VCNT_RESET;
            plim_reg <= PLIM_RESET;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == ADDR_VCNT)
                vcnt_reg <= pwdata[VCNT_W-1:0];
            else
                plim_reg <= pwdata[PLIM_W-1:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == ADDR_VCNT)
                prdata = {{(32-VCNT_W){1'b0}}, vcnt_reg};
            else
                prdata = {{(32-PLIM_W){1'b0}}, plim_reg};
        end
    end

    assign vcnt = vcnt_reg;
    assign plim = plim_reg;
endmodule

FILE: sv/lpc_engine.sv
// ----------------------------------------------------------------------------
// lpc_engine
// Sequencer over label, adjacency and neighbor memories with one shared
// compare unit; handles loads, runs and reads.
// ----------------------------------------------------------------------------
module lpc_engine #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_ENTRIES  = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lpc_pkg::VCNT_W-1:0] vcnt,
    input  logic [lpc_pkg::PLIM_W-1:0] plim,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  lpc_pkg::req_t              in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output lpc_pkg::rsp_t              out_data
);
    import lpc_pkg::*;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int CW = EW + 1;
    localparam int NW = VW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_VSTRT = 4'd2;
    localparam logic [3:0] S_VEND  = 4'd3;
    localparam logic [3:0] S_EADR  = 4'd4;
    localparam logic [3:0] S_ENBR  = 4'd5;
    localparam logic [3:0] S_ELAB  = 4'd6;
    localparam logic [3:0] S_VWR   = 4'd7;
    localparam logic [3:0] S_CCLR  = 4'd8;
    localparam logic [3:0] S_CRD   = 4'd9;
    localparam logic [3:0] S_CCHK  = 4'd10;
    localparam logic [3:0] S_RDW   = 4'd11;
    localparam logic [3:0] S_RD    = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;
    localparam logic [3:0] S_FILL  = 4'd14;

    logic [VW-1:0] lab_mem [MAX_VERTICES];
    logic [VW-1:0] nbr_mem [MAX_ENTRIES];
    logic [CW-1:0] end_mem [MAX_VERTICES];
    logic          seen_mem [MAX_VERTICES];

    logic [3:0]    state_reg;
    logic [CW-1:0] ecnt_reg;
    logic [VW-1:0] last_reg;
    logic          lerr_reg, run_reg;
    logic [NW-1:0] v_reg;
    logic [CW-1:0] k_reg, kend_reg, start_reg;
    logic [VW-1:0] best_reg, own_reg, u_reg;
    logic          chg_reg;
    logic [PLIM_W-1:0] p_reg;
    logic [NW-1:0] c_reg;
    logic [VW-1:0] fill_reg, fill_end_reg;
    logic [VW-1:0] src_reg, nb_reg;
    rsp_t          rsp_reg;
    logic          ovld_reg;

    // the wait step of the seen check writes the mark
    logic [VW-1:0] clab_reg;
    logic          cwait_reg;
    logic          mark_we;

    logic [VW-1:0] lab_q, nbr_q;
    logic [CW-1:0] end_q;
    logic          seen_q;

    logic [NW-1:0] n_eff;
    logic [VW-1:0] v_idx;
    logic          v_last;

    always_comb
    begin
        if (vcnt == '0)
            n_eff = NW'(1);
        else if (32'(vcnt) > MAX_VERTICES)
            n_eff = NW'(MAX_VERTICES);
        else
            n_eff = NW'(vcnt);
    end
    assign v_idx = v_reg[VW-1:0];
    assign v_last = (v_reg + NW'(1)) >= n_eff;

    // memory ports driven by state
    logic          lab_we, end_we, nbr_we, seen_we;
    logic [VW-1:0] lab_wa, lab_wd, lab_ra, end_wa, end_ra, seen_a;
    logic [CW-1:0] end_wd;
    logic [EW-1:0] nbr_ra;
    logic          seen_wd;

    // mark write: wait step of the check, using held label
    assign mark_we = (state_reg == S_CCHK) && cwait_reg;

    always_ff @(posedge clk)
    begin
        if (lab_we) lab_mem[lab_wa] <= lab_wd;
        lab_q <= lab_mem[lab_ra];
        if (nbr_we) nbr_mem[ecnt_reg[EW-1:0]] <= nb_reg;
        nbr_q <= nbr_mem[nbr_ra];
        if (end_we) end_mem[end_wa] <= end_wd;
        end_q <= end_mem[end_ra];
        if (seen_we)
            seen_mem[seen_a] <= seen_wd;
        else if (mark_we)
            seen_mem[clab_reg] <= 1'b1;
        seen_q <= seen_mem[seen_a];
    end

    logic [VW-1:0] cand;
    logic          cand_ok;
    logic          ld_ok;
    logic [CW-1:0] end_eff;
    assign ld_ok = ({1'b0, in_data.vertex} < 11'(n_eff)) && ({1'b0, in_data.neighbor} < 11'(n_eff))
                   && (ecnt_reg == '0 || VW'(in_data.vertex) >= last_reg)
                   && (32'(ecnt_reg) < MAX_ENTRIES);
    // list end: past last source means all entries
    assign end_eff = (ecnt_reg == '0 || v_idx > last_reg) ? ecnt_reg : end_q;
    assign cand_ok = (NW'(u_reg) < n_eff) && (lab_q < best_reg);
    assign cand = cand_ok ? lab_q : best_reg;

    always_comb
    begin
        lab_we = 1'b0; lab_wa = v_idx; lab_wd = v_idx; lab_ra = v_idx;
        end_we = 1'b0; end_wa = fill_reg; end_wd = ecnt_reg; end_ra = v_idx;
        nbr_we = 1'b0; nbr_ra = k_reg[EW-1:0];
        seen_we = 1'b0; seen_a = v_idx; seen_wd = 1'b0;
        case (state_reg)
            S_INIT: lab_we = 1'b1;
            S_FILL:
            begin
                end_we = 1'b1;
                if (fill_reg == fill_end_reg)
                begin
                    end_wd = ecnt_reg + CW'(1);
                    nbr_we = 1'b1;
                end
            end
            S_ELAB: lab_ra = nbr_q;
            S_VWR:
            begin
                lab_we = (best_reg < own_reg);
                lab_wd = best_reg;
            end
            S_CCLR: seen_we = 1'b1;
            S_CRD: lab_ra = v_idx;
            S_CCHK:
            begin
                seen_a = lab_q;
                seen_we = 1'b0;
            end
            S_RDW: lab_ra = src_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ecnt_reg <= '0;
            last_reg <= '0;
            lerr_reg <= 1'b0;
            run_reg <= 1'b0;
            ovld_reg <= 1'b0;
            cwait_reg <= 1'b0;
            rsp_reg <= '0;
        end
        else
        begin
            // result word is cleared once taken, so each request starts from zero
            if (ovld_reg && out_ready)
            begin
                ovld_reg <= 1'b0;
                rsp_reg <= '0;
            end
            case (state_reg)
                S_IDLE:
                    if (in_valid && !ovld_reg)
                    begin
                        src_reg <= VW'(in_data.vertex);
                        nb_reg <= VW'(in_data.neighbor);
                        case (in_data.req_type)
                            REQ_LOAD:
                                if (ld_ok)
                                begin
                                    // repeated source: only its own list end moves
                                    fill_reg <= (ecnt_reg == '0) ? '0 :
                                                (VW'(in_data.vertex) == last_reg) ? last_reg :
                                                last_reg + VW'(1);
                                    fill_end_reg <= VW'(in_data.vertex);
                                    state_reg <= S_FILL;
                                end
                                else
                                begin
                                    lerr_reg <= 1'b1;
                                    rsp_reg.error <= 1'b1;
                                    ovld_reg <= 1'b1;
                                end
                            REQ_RUN:
                            begin
                                v_reg <= '0;
                                p_reg <= '0;
                                chg_reg <= 1'b0;
                                state_reg <= S_INIT;
                            end
                            REQ_READ:
                                if ({1'b0, in_data.vertex} >= 11'(n_eff))
                                begin
                                    rsp_reg.error <= 1'b1;
                                    ovld_reg <= 1'b1;
                                end
                                else if (!run_reg)
                                begin
                                    rsp_reg.label <= in_data.vertex;
                                    ovld_reg <= 1'b1;
                                end
                                else
                                    state_reg <= S_RDW;
                            default: ;
                        endcase
                    end
                S_FILL:
                begin
                    if (fill_reg == fill_end_reg)
                    begin
                        ecnt_reg <= ecnt_reg + CW'(1);
                        last_reg <= fill_end_reg;
                        ovld_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    fill_reg <= fill_reg + VW'(1);
                end
                S_INIT:
                begin
                    if (32'(v_reg) == MAX_VERTICES - 1)
                    begin
                        v_reg <= '0;
                        start_reg <= '0;
                        chg_reg <= 1'b0;
                        state_reg <= (plim == '0) ? S_CCLR : S_VSTRT;
                    end
                    else
                        v_reg <= v_reg + NW'(1);
                end
                S_VSTRT: state_reg <= S_VEND;  // end_q, lab_q valid next
                S_VEND:
                begin
                    best_reg <= lab_q;
                    own_reg <= lab_q;
                    k_reg <= start_reg;
                    kend_reg <= (32'(end_eff) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : end_eff;
                    state_reg <= S_EADR;
                end
                S_EADR:
                    if (k_reg < kend_reg)
                        state_reg <= S_ENBR;
                    else
                        state_reg <= S_VWR;
                S_ENBR: state_reg <= S_ELAB;
                S_ELAB:
                begin
                    u_reg <= nbr_q;
                    // hold on a wait step until the label of the neighbor is read
                    if (cwait_reg)
                    begin
                        cwait_reg <= 1'b0;
                        best_reg <= cand;
                        k_reg <= k_reg + CW'(1);
                        state_reg <= S_EADR;
                    end
                    else
                        cwait_reg <= 1'b1;
                end
                S_VWR:
                begin
                    if (v_last)
                    begin
                        p_reg <= p_reg + PLIM_W'(1);
                        v_reg <= '0;
                        start_reg <= '0;
                        chg_reg <= 1'b0;
                        if ((p_reg + PLIM_W'(1)) < plim && (chg_reg || best_reg < own_reg))
                            state_reg <= S_VSTRT;
                        else
                        begin
                            rsp_reg.converged <= !(chg_reg || best_reg < own_reg);
                            state_reg <= S_CCLR;
                        end
                    end
                    else
                    begin
                        if (best_reg < own_reg) chg_reg <= 1'b1;
                        if (kend_reg > start_reg) start_reg <= kend_reg;
                        v_reg <= v_reg + NW'(1);
                        state_reg <= S_VSTRT;
                    end
                end
                S_CCLR:
                begin
                    if (32'(v_reg) == MAX_VERTICES - 1)
                    begin
                        v_reg <= '0;
                        c_reg <= '0;
                        state_reg <= S_CRD;
                    end
                    else
                        v_reg <= v_reg + NW'(1);
                end
                S_CRD: state_reg <= S_CCHK;
                S_CCHK:
                begin
                    // lab_q valid now; seen read lands next cycle
                    if (!cwait_reg)
                    begin
                        cwait_reg <= 1'b1;
                        clab_reg <= lab_q;
                    end
                    else
                    begin
                        cwait_reg <= 1'b0;
                        if (!seen_q) c_reg <= c_reg + NW'(1);
                        if (v_last)
                            state_reg <= S_OUT;
                        else
                        begin
                            v_reg <= v_reg + NW'(1);
                            state_reg <= S_CRD;
                        end
                    end
                end
                S_RDW: state_reg <= S_RD;
                S_RD:
                begin
                    rsp_reg.label <= 10'(lab_q);
                    ovld_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_OUT:
                begin
                    rsp_reg.component_count <= 11'(c_reg);
                    rsp_reg.pass_count <= p_reg;
                    rsp_reg.error <= lerr_reg;
                    run_reg <= 1'b1;
                    ovld_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE) && !ovld_reg;
    assign out_valid = ovld_reg;
    assign out_data = rsp_reg;
endmodule

FILE: sv/lpc_checker.sv
// ----------------------------------------------------------------------------
// lpc_checker
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
`include "label_propagation_components_macros.svh"
module lpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_type,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       pready
);
    import lpc_pkg::*;

    `LPC_ASSERT_IMPL(a_no_take_while_result, clk, rst_n, rsp_valid, !req_ready,
                     "accepted word while result pending")
    `LPC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid,
                     "result dropped under stall")
    `LPC_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, pready, "pready low")
    // a dropped word frees the block at once
    `LPC_ASSERT_NEXT(a_busy_after_take, clk, rst_n,
                     req_valid && req_ready && req_type != REQ_NOP, !req_ready,
                     "took two words back to back")
endmodule

bind label_propagation_components lpc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .req_valid(req.valid), .req_ready(req.ready),
    .req_type(req.data.req_type),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .pready(pready)
);
